// ===== rtl/core/mtap_pkg.sv =====
// ----------------------------------------------------------------------------
// mtap_pkg
// shared types and constants for the motion to arrow tap converter
// ----------------------------------------------------------------------------
package mtap_pkg;

	// accumulator and threshold widths
	localparam int ACC_W  = 32;
	localparam int THR_W  = 16;
	localparam int PROD_W = ACC_W + THR_W;

	// event kind field
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_X = 2'd0;
	localparam logic [KIND_W-1:0] KIND_Y = 2'd1;

	// tap direction codes
	localparam int DIR_W = 2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

	// parameter defaults
	localparam int DEF_MAX_TAPS     = 4;
	localparam int DEF_MOTION_WIDTH = 16;
	localparam int DEF_QUEUE_DEPTH  = 2;

	// register map
	localparam int ADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_HTHR = 1'b0;
	localparam logic REG_VTHR = 1'b1;
	localparam logic [THR_W-1:0] THR_RESET = 16'd16;

	// front/queue handshake
	typedef struct packed {
		logic push;
	} mtap_push_t;

	typedef struct packed {
		logic full;
	} mtap_qstat_t;

endpackage

// ===== rtl/core/motion_to_arrow_tap_converter_core.sv =====
// ----------------------------------------------------------------------------
// motion_to_arrow_tap_converter_core
// turns relative pointer motion into left, right, up and down tap beats
// ----------------------------------------------------------------------------
// a motion beat without the sync mark, or an ignored kind, is taken without blocking input
// a motion beat with sync holds the input while the front sequencer runs: two passes
// of one shared multiplier, a select step, one compare-subtract step per tap (up to
// MAX_TAPS taps) and a done step that waits while the burst queue is full
// a burst reaches the output through the burst queue and the registered output stage
// taps of a burst leave one per cycle while the consumer takes them
// reset clears both accumulators, the queue and the output stage; thresholds reset to 16
module motion_to_arrow_tap_converter_core import mtap_pkg::*; #(
	parameter int MAX_TAPS     = DEF_MAX_TAPS,
	parameter int MOTION_WIDTH = DEF_MOTION_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((MOTION_WIDTH + 7) / 8)*8-1:0] s_tdata,  // motion
	input  logic [KIND_W-1:0]                     s_tuser,  // event_kind
	input  logic                                  s_tlast,  // sync
	// output stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,  // tap_direction, zero fill
	output logic                                  m_tlast,  // last_tap
	// register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ADDR_W-1:0]                     paddr,
	input  logic [PDATA_W-1:0]                    pwdata,
	output logic [PDATA_W-1:0]                    prdata,
	output logic                                  pready
);

	localparam int CNT_W   = $clog2(MAX_TAPS + 1);
	localparam int ENTRY_W = DIR_W + CNT_W;

	logic [THR_W-1:0]   hthr_q;
	logic [THR_W-1:0]   vthr_q;
	logic               reg_wr;

	mtap_push_t         q_ctl;
	mtap_qstat_t        q_stat;
	logic [DIR_W-1:0]   f_dir;
	logic [CNT_W-1:0]   f_count;
	logic [ENTRY_W-1:0] q_rd_data;
	logic               q_valid;
	logic               q_pop;
	logic [DIR_W-1:0]   tap_dir;

	// register block: writes land on the access phase, reads are plain muxes
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hthr_q <= THR_RESET;
			vthr_q <= THR_RESET;
		end else if (reg_wr) begin
			case (paddr[2])
				REG_HTHR: hthr_q <= pwdata[THR_W-1:0];
				REG_VTHR: vthr_q <= pwdata[THR_W-1:0];
				default:  hthr_q <= hthr_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HTHR: prdata = PDATA_W'(hthr_q);
			REG_VTHR: prdata = PDATA_W'(vthr_q);
			default:  prdata = '0;
		endcase
	end

	// front: accumulate, evaluate on sync, count taps
	mtap_front #(
		.MAX_TAPS     (MAX_TAPS),
		.MOTION_WIDTH (MOTION_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_motion (s_tdata[MOTION_WIDTH-1:0]),
		.in_sync   (s_tlast),
		.hthr      (hthr_q),
		.vthr      (vthr_q),
		.q_ctl     (q_ctl),
		.q_dir     (f_dir),
		.q_count   (f_count),
		.q_stat    (q_stat)
	);

	// burst queue decouples evaluation from output stalls
	mtap_queue #(
		.DEPTH (DEF_QUEUE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_ctl   (q_ctl),
		.wr_data  ({f_dir, f_count}),
		.stat     (q_stat),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	// back: one beat per tap, last beat of a burst flagged
	mtap_back #(
		.MAX_TAPS (MAX_TAPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_dir     (q_rd_data[ENTRY_W-1:CNT_W]),
		.q_count   (q_rd_data[CNT_W-1:0]),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_dir   (tap_dir),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(8 - DIR_W){1'b0}}, tap_dir};

endmodule

// ===== rtl/core/mtap_queue.sv =====
// ----------------------------------------------------------------------------
// mtap_queue
// small fifo of tap bursts between the front and the back
// ----------------------------------------------------------------------------
module mtap_queue import mtap_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mtap_push_t       wr_ctl,
	input  logic [WIDTH-1:0] wr_data,
	output mtap_qstat_t      stat,
	input  logic             pop,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full = (count_q == FULL_CNT);
	assign rd_valid  = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];
	assign do_push   = wr_ctl.push && !stat.full;
	assign do_pop    = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/mtap_front.sv =====
// ----------------------------------------------------------------------------
// mtap_front
// accumulates motion, evaluates on sync and queues at most one tap burst per report
// ----------------------------------------------------------------------------
module mtap_front import mtap_pkg::*; #(
	parameter int MAX_TAPS     = DEF_MAX_TAPS,
	parameter int MOTION_WIDTH = DEF_MOTION_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [KIND_W-1:0]               in_kind,
	input  logic signed [MOTION_WIDTH-1:0]  in_motion,
	input  logic                            in_sync,
	input  logic [THR_W-1:0]                hthr,
	input  logic [THR_W-1:0]                vthr,
	output mtap_push_t                      q_ctl,
	output logic [DIR_W-1:0]                q_dir,
	output logic [$clog2(MAX_TAPS+1)-1:0]   q_count,
	input  mtap_qstat_t                     q_stat
);

	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TAPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_SEL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [ACC_W-1:0]  x_acc_q;
	logic [ACC_W-1:0]  y_acc_q;
	logic [PROD_W-1:0] hprog_q;
	logic [PROD_W-1:0] vprog_q;
	logic              axis_y_q;
	logic              neg_q;
	logic [THR_W-1:0]  thr_q;
	logic [ACC_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [THR_W-1:0]  hthr_eff;
	logic [THR_W-1:0]  vthr_eff;
	logic              accept;
	logic [ACC_W:0]    sel_acc;
	logic [ACC_W:0]    delta;
	logic [ACC_W:0]    sum;
	logic [ACC_W-1:0]  sat_sum;
	logic [ACC_W-1:0]  x_mag;
	logic [ACC_W-1:0]  y_mag;
	logic [ACC_W-1:0]  mul_a;
	logic [THR_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;
	logic              pick_x;
	logic [ACC_W-1:0]  dom_acc;
	logic [ACC_W-1:0]  rem_signed;

	assign hthr_eff = (hthr == '0) ? THR_W'(1) : hthr;
	assign vthr_eff = (vthr == '0) ? THR_W'(1) : vthr;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// saturating add of the sign-extended delta
	assign sel_acc = (in_kind == KIND_X) ? {x_acc_q[ACC_W-1], x_acc_q}
	                                     : {y_acc_q[ACC_W-1], y_acc_q};
	assign delta   = {{(ACC_W + 1 - MOTION_WIDTH){in_motion[MOTION_WIDTH-1]}}, in_motion};
	assign sum     = sel_acc + delta;
	always_comb begin
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			sat_sum = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_sum = sum[ACC_W-1:0];
		end
	end

	assign x_mag = x_acc_q[ACC_W-1] ? (~x_acc_q + 1'b1) : x_acc_q;
	assign y_mag = y_acc_q[ACC_W-1] ? (~y_acc_q + 1'b1) : y_acc_q;

	// one shared multiplier for both progress products
	assign mul_a = (state_q == ST_MULX) ? x_mag : y_mag;
	assign mul_b = (state_q == ST_MULX) ? vthr_eff : hthr_eff;
	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign pick_x     = (hprog_q >= vprog_q);
	assign dom_acc    = pick_x ? x_acc_q : y_acc_q;
	assign rem_signed = neg_q ? (~rem_q + 1'b1) : rem_q;

	assign q_ctl.push = (state_q == ST_DONE) && (cnt_q != '0);
	assign q_count    = cnt_q;
	always_comb begin
		case ({axis_y_q, neg_q})
			2'b00:   q_dir = DIR_RIGHT;
			2'b01:   q_dir = DIR_LEFT;
			2'b10:   q_dir = DIR_DOWN;
			2'b11:   q_dir = DIR_UP;
			default: q_dir = DIR_RIGHT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			x_acc_q  <= '0;
			y_acc_q  <= '0;
			hprog_q  <= '0;
			vprog_q  <= '0;
			axis_y_q <= 1'b0;
			neg_q    <= 1'b0;
			thr_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_kind == KIND_X || in_kind == KIND_Y)) begin
						if (in_kind == KIND_X) begin
							x_acc_q <= sat_sum;
						end else begin
							y_acc_q <= sat_sum;
						end
						if (in_sync) begin
							state_q <= ST_MULX;
						end
					end
				end
				ST_MULX: begin
					hprog_q <= prod;
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					vprog_q <= prod;
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					axis_y_q <= !pick_x;
					neg_q    <= dom_acc[ACC_W-1];
					thr_q    <= pick_x ? hthr_eff : vthr_eff;
					rem_q    <= pick_x ? x_mag : y_mag;
					cnt_q    <= '0;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					// one compare and subtract per cycle, capped at the tap limit
					if (cnt_q != CNT_MAX && rem_q >= ACC_W'(thr_q)) begin
						rem_q <= rem_q - ACC_W'(thr_q);
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else if (!q_stat.full) begin
						if (axis_y_q) begin
							y_acc_q <= rem_signed;
							x_acc_q <= '0;
						end else begin
							x_acc_q <= rem_signed;
							y_acc_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/mtap_back.sv =====
// ----------------------------------------------------------------------------
// mtap_back
// expands queued bursts into single tap beats on a registered output
// ----------------------------------------------------------------------------
module mtap_back import mtap_pkg::*; #(
	parameter int MAX_TAPS = DEF_MAX_TAPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  logic [DIR_W-1:0]              q_dir,
	input  logic [$clog2(MAX_TAPS+1)-1:0] q_count,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DIR_W-1:0]              out_dir,
	output logic                          out_last
);

	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	logic             valid_q;
	logic [DIR_W-1:0] dir_q;
	logic             last_q;
	logic [CNT_W-1:0] left_q;
	logic             advance;

	assign advance   = !valid_q || out_ready;
	assign q_pop     = advance && (left_q == '0) && q_valid;
	assign out_valid = valid_q;
	assign out_dir   = dir_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dir_q <= q_dir;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			left_q  <= '0;
		end else if (advance) begin
			if (left_q != '0) begin
				valid_q <= 1'b1;
				last_q  <= (left_q == ONE);
				left_q  <= left_q - 1'b1;
			end else if (q_valid) begin
				valid_q <= 1'b1;
				last_q  <= (q_count == ONE);
				left_q  <= q_count - 1'b1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/mtap_checker.sv =====
// ----------------------------------------------------------------------------
// mtap_checker
// port-level checks for the motion to arrow tap converter
// ----------------------------------------------------------------------------
module mtap_checker import mtap_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [KIND_W-1:0] s_tuser,
	input logic              s_tlast,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [7:0]        m_tdata,
	input logic              m_tlast
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// a synced motion beat starts an evaluation that blocks input
	a_sync_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast && (s_tuser == KIND_X || s_tuser == KIND_Y)
		|=> !s_tready)
		else $error("input taken during evaluation");

	// plain motion is absorbed without blocking input
	a_plain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("input stalled after unsynced beat");

	// taps of a burst follow without gaps and keep their direction
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast
		|=> m_tvalid && (m_tdata[DIR_W-1:0] == $past(m_tdata[DIR_W-1:0])))
		else $error("burst broken before its last tap");

endmodule

bind motion_to_arrow_tap_converter_core mtap_checker u_mtap_checker (.*);

// ===== verif/mtap_tap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtap_tap_checker
// watches the motion, tap and register channels, keeps its own accumulator
// and threshold copies, predicts the tap beats and compares them in order
// ----------------------------------------------------------------------------
module mtap_tap_checker import mtap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [15:0]        s_tdata,   // motion
	input  logic [KIND_W-1:0]  s_tuser,   // event_kind
	input  logic               s_tlast,   // sync
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [7:0]         m_tdata,   // tap_direction, zero fill
	input  logic               m_tlast,   // last_tap
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 fail_count,
	output int                 taps_owed
);

	typedef struct {
		logic [DIR_W-1:0] dir;
		logic             last;
	} tap_t;

	tap_t                    tap_q[$];
	logic signed [ACC_W-1:0] x_sum;
	logic signed [ACC_W-1:0] y_sum;
	logic [THR_W-1:0]        h_step;
	logic [THR_W-1:0]        v_step;

	initial fail_count = 0;
	initial taps_owed = 0;

	function automatic logic signed [ACC_W-1:0] clamp_add(
		input logic signed [ACC_W-1:0] acc,
		input logic signed [15:0]      delta
	);
		longint s;
		s = longint'(acc) + longint'(delta);
		if (s > 64'sd2147483647)
			s = 64'sd2147483647;
		if (s < -64'sd2147483648)
			s = -64'sd2147483648;
		return s[ACC_W-1:0];
	endfunction

	function automatic longint abs_acc(input logic signed [ACC_W-1:0] v);
		longint w;
		w = longint'(v);
		return (w < 0) ? -w : w;
	endfunction

	// update the accumulators for one motion beat and queue the taps it causes
	task automatic predict_taps(
		input logic [KIND_W-1:0] kind,
		input logic signed [15:0] delta,
		input logic               sync
	);
		longint           h_eff, v_eff, mag, step, cnt, rest;
		logic             x_wins, neg;
		logic [DIR_W-1:0] dir;
		tap_t             t;
		if (kind != KIND_X && kind != KIND_Y)
			return;
		if (kind == KIND_X)
			x_sum = clamp_add(x_sum, delta);
		else
			y_sum = clamp_add(y_sum, delta);
		if (!sync)
			return;
		h_eff = (h_step == '0) ? 1 : longint'(h_step);
		v_eff = (v_step == '0) ? 1 : longint'(v_step);
		// cross-multiplied progress, a tie goes to x
		x_wins = abs_acc(x_sum) * v_eff >= abs_acc(y_sum) * h_eff;
		mag  = x_wins ? abs_acc(x_sum) : abs_acc(y_sum);
		step = x_wins ? h_eff : v_eff;
		cnt  = mag / step;
		if (cnt > DEF_MAX_TAPS)
			cnt = DEF_MAX_TAPS;
		if (cnt == 0)
			return;
		neg  = x_wins ? x_sum[ACC_W-1] : y_sum[ACC_W-1];
		rest = mag - cnt * step;
		if (neg)
			rest = -rest;
		if (x_wins) begin
			x_sum = rest[ACC_W-1:0];
			y_sum = '0;
			dir   = neg ? DIR_LEFT : DIR_RIGHT;
		end else begin
			y_sum = rest[ACC_W-1:0];
			x_sum = '0;
			dir   = neg ? DIR_UP : DIR_DOWN;
		end
		for (longint k = 0; k < cnt; k++) begin
			t.dir  = dir;
			t.last = (k + 1 == cnt);
			tap_q.push_back(t);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tap_t want;
		if (!arst_n) begin
			x_sum  = '0;
			y_sum  = '0;
			h_step = THR_RESET;
			v_step = THR_RESET;
			tap_q.delete();
			taps_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[ADDR_W-1:2] == REG_HTHR)
					h_step = pwdata[THR_W-1:0];
				else
					v_step = pwdata[THR_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (tap_q.size() == 0) begin
					$error("unexpected tap beat: tap_direction %0d last_tap %0b",
						m_tdata[DIR_W-1:0], m_tlast);
					fail_count++;
				end else begin
					want = tap_q.pop_front();
					if (m_tdata[DIR_W-1:0] !== want.dir) begin
						$error("tap_direction: expected %0d, got %0d",
							want.dir, m_tdata[DIR_W-1:0]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last_tap: expected %0b, got %0b", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_taps(s_tuser, $signed(s_tdata), s_tlast);
			taps_owed <= tap_q.size();
		end
	end

endmodule

// ===== verif/motion_to_arrow_tap_converter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_to_arrow_tap_converter_core_tb
// drives motion beats and threshold writes into the tap converter, with a
// directed opening and randomized phases under several sender and receiver
// idling patterns; the checker beside the block predicts every tap beat and
// counts mismatches
// ----------------------------------------------------------------------------
module motion_to_arrow_tap_converter_core_tb;
	import mtap_pkg::*;

	// event kinds the block ignores
	localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// random beats per phase and number of phases
	localparam int PHASE_BEATS = 56;
	localparam int NUM_PHASES  = 8;
	// quiet cycles after the last tap: covers a sync beat that causes no tap
	localparam int SETTLE = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;        // motion
	logic [KIND_W-1:0] s_tuser = KIND_X;    // event_kind
	logic              s_tlast = 1'b0;      // sync

	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;             // tap_direction, zero fill
	logic              m_tlast;             // last_tap

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int taps_owed;

	// idling odds in percent, changed only between phases
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// thresholds as last written, used only to scale the random motion
	int h_cur = THR_RESET;
	int v_cur = THR_RESET;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	motion_to_arrow_tap_converter_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	mtap_tap_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.taps_owed  (taps_owed)
	);

	// tap consumer: drops ready at random at the current stall odds
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// one motion beat, with random idle cycles in front at the current odds;
	// returns at the edge where the beat is taken, valid still high
	task automatic send_motion(
		input logic [KIND_W-1:0] kind,
		input logic [15:0]       motion,
		input logic              sync
	);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= motion;
		s_tlast  <= sync;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// hold the sender until every predicted tap is out and the block is quiet
	task automatic drain_taps();
		s_tvalid <= 1'b0;
		// the owed count is registered, so let it update before looking
		@(posedge clk);
		while (taps_owed != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write: setup phase, then access until pready, then back to idle
	task automatic write_thr(input logic idx, input logic [THR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(PDATA_W-THR_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// random beat: mostly x or y motion scaled to up to three taps' worth, some
	// full-range deltas and a few ignored kinds
	task automatic send_random();
		int               pick, lim, eff;
		logic [KIND_W-1:0] kind;
		logic [15:0]      motion;
		logic             sync;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			kind = KIND_X;
		else if (pick < 90)
			kind = KIND_Y;
		else
			kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE;
		eff = (kind == KIND_Y) ? v_cur : h_cur;
		if (eff == 0)
			eff = 1;
		lim = 3 * eff;
		if (lim > 32767)
			lim = 32767;
		if ($urandom_range(0, 99) < 12)
			motion = 16'($urandom());
		else
			motion = 16'($urandom_range(0, 2 * lim) - lim);
		sync = ($urandom_range(0, 99) < 35);
		send_motion(kind, motion, sync);
	endtask

	initial begin
		int h_set[NUM_PHASES];
		int v_set[NUM_PHASES];

		// thresholds per phase: reset value, zero read as one, both maxima,
		// lopsided pairs, then random small values
		h_set = '{16, 0, 65535, 1, 5, 300, 0, 0};
		v_set = '{16, 0, 65535, 65535, 1, 40, 0, 0};
		h_set[6] = $urandom_range(1, 200);
		v_set[6] = $urandom_range(1, 200);
		h_set[7] = $urandom_range(1, 200);
		v_set[7] = $urandom_range(1, 200);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening at the reset thresholds of 16
		// ignored kinds, even with sync set
		send_motion(KIND_OTHER, 16'd100, 1'b1);
		send_motion(KIND_SPARE, 16'hffff, 1'b1);
		// just below one tap: nothing comes out
		send_motion(KIND_X, 16'd15, 1'b1);
		// reaches one tap exactly
		send_motion(KIND_X, 16'd1, 1'b1);
		// four taps up
		send_motion(KIND_Y, -16'sd64, 1'b1);
		// y builds without sync, then a strong left move wins
		send_motion(KIND_Y, 16'sh7fff, 1'b0);
		send_motion(KIND_X, 16'sh8000, 1'b1);
		// bring x back to zero, then set up equal progress on both axes
		send_motion(KIND_X, 16'd32704, 1'b0);
		send_motion(KIND_Y, 16'd20, 1'b0);
		send_motion(KIND_X, 16'd20, 1'b1);
		// both accumulators at zero on sync
		send_motion(KIND_X, -16'sd4, 1'b1);
		// three taps down, then a zero delta with sync
		send_motion(KIND_Y, 16'd48, 1'b1);
		send_motion(KIND_Y, 16'd0, 1'b1);
		// more than four taps' worth is capped, the rest stays behind
		send_motion(KIND_X, -16'sd200, 1'b1);
		send_motion(KIND_X, 16'd0, 1'b1);
		send_motion(KIND_Y, 16'hffff, 1'b1);
		drain_taps();

		// random phases: new thresholds while idle, idling pattern cycles
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_thr(REG_HTHR, h_set[p][THR_W-1:0]);
			write_thr(REG_VTHR, v_set[p][THR_W-1:0]);
			h_cur = h_set[p];
			v_cur = v_set[p];
			case (p % 4)
				0: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  <= 82;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 82;
				end
				default: begin
					send_idle_pct  <= 17;
					recv_stall_pct <= 17;
				end
			endcase
			@(posedge clk);
			repeat (PHASE_BEATS) send_random();
			drain_taps();
		end

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit, well past the slowest correct run
	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
